[rtl/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned SIZE_W = 24;

   localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'd65536;
   localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'd16777216;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_LIMIT = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_RESOLVE
   } state_type;

   // Search token walking down the cell row.
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [ADDR_W-1:0] addr;
   } tok_type;

   // One table entry, also what shifts from cell to cell on a push.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] len;
      logic              free;
   } entry_type;

   // Command broadcast to every cell.
   typedef struct packed {
      op_type            op;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              push;
   } cmd_type;

endpackage

[rtl/ffba_if.sv]
// Handshake channels of the first-fit block allocator.
interface ffba_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [23:0] req_size;
   logic [31:0] free_addr;

   modport source (output valid, output opcode, output req_size, output free_addr,
                   input ready);
   modport sink   (input valid, input opcode, input req_size, input free_addr,
                   output ready);
endinterface

interface ffba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] block_addr;
   logic [1:0]  status;

   modport source (output valid, output block_addr, output status, input ready);
   modport sink   (input valid, input block_addr, input status, output ready);
endinterface

interface ffba_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/ffba_cell.sv]
// One table cell: holds a block entry, checks the passing search token, shifts on a push.
module ffba_cell #(
   parameter int unsigned INDEX   = 0,
   parameter int unsigned COUNT_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  ffba_pkg::cmd_type   cmd,
   input  logic [COUNT_W-1:0]  count,
   input  ffba_pkg::tok_type   tok_in,
   output ffba_pkg::tok_type   tok_out,
   input  ffba_pkg::entry_type shift_in,
   output ffba_pkg::entry_type shift_out
);

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

   logic [ffba_pkg::ADDR_W-1:0] addr_ff;
   logic [ffba_pkg::SIZE_W-1:0] len_ff;
   logic                        free_ff;
   logic                        free_in;
   ffba_pkg::tok_type           tok_ff;
   ffba_pkg::tok_type           tok_in_n;
   logic                        live;
   logic                        match;
   logic                        claim;

   assign live  = count > MY_INDEX;
   assign match = (cmd.op == ffba_pkg::OP_FREE) ? (addr_ff == cmd.addr)
                                                : (free_ff && (len_ff >= cmd.size));
   assign claim = tok_in.valid && !tok_in.hit && live && match;

   always_comb begin
      tok_in_n       = tok_in;
      tok_in_n.hit   = tok_in.hit || claim;
      tok_in_n.addr  = claim ? addr_ff : tok_in.addr;
      if (cmd.push) begin
         free_in = shift_in.free;
      end else if (claim) begin
         free_in = (cmd.op == ffba_pkg::OP_FREE);
      end else begin
         free_in = free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         free_ff <= free_in;
         tok_ff  <= tok_in_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         addr_ff <= shift_in.addr;
         len_ff  <= shift_in.len;
      end
   end

   assign tok_out        = tok_ff;
   assign shift_out.addr = addr_ff;
   assign shift_out.len  = len_ff;
   assign shift_out.free = free_ff;

endmodule

[rtl/first_fit_block_allocator_core.sv]
// Top level of the first-fit block allocator: control, break pointer and the cell row.
//
// Usage: req_ch carries one allocate or free word (opcode, req_size, free_addr).
// rsp_ch returns exactly one word per request (block_addr, status) in request order.
// csr_ch writes heap_base (index 0) or heap_limit (index 1); it is always ready
// and must only be used while no request is in flight.
// The table is a row of ENTRIES cells with the newest block in cell 0. A request
// launches a search token into cell 0 that moves one cell per cycle; the first
// matching cell claims it. A new block is pushed into cell 0 and the row shifts.
// A search runs from launch_ff through the token register of every cell to the end
// of the row, then through the resolve step into the output register; a zero-size
// allocate or a null free goes straight to the resolve step. One request at a time:
// the next is accepted only after the resolve step, at a pace set by the token walk.
// Reset (synchronous) empties the table, loads heap_base 65536, heap_limit
// 16777216 and the break pointer from heap_base.
// When the receiver stalls, the result holds in the output register and the
// next request's result waits in the resolve step until the register frees.
module first_fit_block_allocator_core #(
   parameter int unsigned ENTRIES      = 64,
   parameter int unsigned HEADER_BYTES = 24
) (
   input  logic       clock,
   input  logic       reset,
   ffba_req_if.sink   req_ch,
   ffba_rsp_if.source rsp_ch,
   ffba_csr_if.sink   csr_ch
);

   localparam int unsigned COUNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned SUM_W   = ffba_pkg::ADDR_W + 2;
   localparam logic [COUNT_W-1:0] FULL = COUNT_W'(ENTRIES);

   ffba_pkg::state_type state_ff, state_in;

   // request held for the search
   ffba_pkg::op_type            op_ff, op_in;
   logic [ffba_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ffba_pkg::ADDR_W-1:0] faddr_ff, faddr_in;
   logic                        launch_ff, launch_in;
   logic                        short_ff, short_in;
   ffba_pkg::status_type        short_st_ff, short_st_in;
   logic                        hit_ff, hit_in;
   logic [ffba_pkg::ADDR_W-1:0] hit_addr_ff, hit_addr_in;

   // allocator state and registers
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic [ffba_pkg::ADDR_W-1:0] brk_ff, brk_in;
   logic [ffba_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [ffba_pkg::ADDR_W-1:0] limit_ff, limit_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ffba_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   ffba_pkg::status_type        rsp_st_ff, rsp_st_in;

   logic [SUM_W-1:0]            new_break;
   logic [ffba_pkg::ADDR_W-1:0] hdr_addr;
   logic                        slot_free;
   logic                        push;
   ffba_pkg::cmd_type           cmd;
   ffba_pkg::entry_type         new_entry;
   ffba_pkg::tok_type           tok_head;
   ffba_pkg::tok_type           tok_link [ENTRIES];
   ffba_pkg::entry_type         ent_link [ENTRIES];

   assign new_break = {2'b00, brk_ff} + SUM_W'(HEADER_BYTES) + SUM_W'(size_ff);
   assign hdr_addr  = brk_ff + ffba_pkg::ADDR_W'(HEADER_BYTES);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ffba_pkg::S_IDLE);
   assign csr_ch.ready = 1'b1;

   // Next state, result and table update.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      faddr_in     = faddr_ff;
      launch_in    = 1'b0;
      short_in     = short_ff;
      short_st_in  = short_st_ff;
      hit_in       = hit_ff;
      hit_addr_in  = hit_addr_ff;
      count_in     = count_ff;
      brk_in       = brk_ff;
      base_in      = base_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      push         = 1'b0;

      unique case (state_ff)
         ffba_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = ffba_pkg::op_type'(req_ch.opcode);
               size_in  = req_ch.req_size;
               faddr_in = req_ch.free_addr;
               if (req_ch.opcode == ffba_pkg::OP_ALLOC && req_ch.req_size == '0) begin
                  short_in    = 1'b1;
                  short_st_in = ffba_pkg::ST_ZERO;
                  state_in    = ffba_pkg::S_RESOLVE;
               end else if (req_ch.opcode == ffba_pkg::OP_FREE && req_ch.free_addr == '0) begin
                  short_in    = 1'b1;
                  short_st_in = ffba_pkg::ST_IGNORED;
                  state_in    = ffba_pkg::S_RESOLVE;
               end else begin
                  short_in  = 1'b0;
                  launch_in = 1'b1;
                  state_in  = ffba_pkg::S_SWEEP;
               end
            end
         end
         ffba_pkg::S_SWEEP: begin
            // wait for the token to leave the last cell
            if (tok_link[ENTRIES-1].valid) begin
               hit_in      = tok_link[ENTRIES-1].hit;
               hit_addr_in = tok_link[ENTRIES-1].addr;
               state_in    = ffba_pkg::S_RESOLVE;
            end
         end
         ffba_pkg::S_RESOLVE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = '0;
               state_in     = ffba_pkg::S_IDLE;
               if (short_ff) begin
                  rsp_st_in = short_st_ff;
               end else if (hit_ff) begin
                  rsp_st_in = ffba_pkg::ST_OK;
                  if (op_ff == ffba_pkg::OP_ALLOC) begin
                     rsp_addr_in = hit_addr_ff;
                  end
               end else if (op_ff == ffba_pkg::OP_FREE) begin
                  rsp_st_in = ffba_pkg::ST_IGNORED;
               end else if (count_ff == FULL) begin
                  rsp_st_in = ffba_pkg::ST_NOSPACE;
               end else if (new_break > {2'b00, limit_ff}) begin
                  rsp_st_in = ffba_pkg::ST_NOSPACE;
               end else begin
                  // cut a new block at the break and push it into cell 0
                  rsp_st_in   = ffba_pkg::ST_OK;
                  rsp_addr_in = hdr_addr;
                  push        = 1'b1;
                  count_in    = count_ff + 1'b1;
                  brk_in      = new_break[ffba_pkg::ADDR_W-1:0];
               end
            end
         end
         default: begin
            state_in = ffba_pkg::S_IDLE;
         end
      endcase

      // Register writes must arrive only while idle; the block itself does not enforce it.
      if (csr_ch.valid) begin
         unique case (ffba_pkg::csr_type'(csr_ch.index))
            ffba_pkg::CSR_HEAP_BASE: begin
               base_in = csr_ch.data;
               if (count_ff == '0) begin
                  brk_in = csr_ch.data;
               end
            end
            ffba_pkg::CSR_HEAP_LIMIT: begin
               limit_in = csr_ch.data;
            end
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::S_IDLE;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         brk_ff       <= ffba_pkg::HEAP_BASE_RESET;
         base_ff      <= ffba_pkg::HEAP_BASE_RESET;
         limit_ff     <= ffba_pkg::HEAP_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         short_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         short_ff     <= short_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      size_ff     <= size_in;
      faddr_ff    <= faddr_in;
      short_st_ff <= short_st_in;
      hit_addr_ff <= hit_addr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // Broadcast command and the head of both chains.
   assign cmd.op   = op_ff;
   assign cmd.size = size_ff;
   assign cmd.addr = faddr_ff;
   assign cmd.push = push;

   assign tok_head.valid = launch_ff;
   assign tok_head.hit   = 1'b0;
   assign tok_head.addr  = '0;

   assign new_entry.addr = hdr_addr;
   assign new_entry.len  = size_ff;
   assign new_entry.free = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         ffba_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .count     (count_ff),
            .tok_in    (tok_head),
            .tok_out   (tok_link[i]),
            .shift_in  (new_entry),
            .shift_out (ent_link[i])
         );
      end else begin : g_body
         ffba_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .count     (count_ff),
            .tok_in    (tok_link[i-1]),
            .tok_out   (tok_link[i]),
            .shift_in  (ent_link[i-1]),
            .shift_out (ent_link[i])
         );
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.block_addr = rsp_addr_ff;
   assign rsp_ch.status     = rsp_st_ff;

endmodule
